// File: design/pcf_pkg.sv
// Shared widths, register codes and side-band word types of the penalty contact force pipeline.
package pcf_pkg;

    localparam int NLANE    = 3;
    localparam int IN_W     = 32;
    localparam int GAIN_W   = 32;
    localparam int OUT_W    = 48;
    localparam int FRAC_W   = 16;

    localparam int DIF_W    = 33;   // offset and relative velocity, signed
    localparam int SQ_W     = 66;   // products, |d|^2, v.d parts
    localparam int HALF_W   = 33;   // split of a 66-bit operand
    localparam int NUM_W    = 99;   // |v.d| * |d_i|
    localparam int ND_W     = 33;   // isqrt(|d|^2)
    localparam int VN_W     = 35;   // normal velocity magnitude
    localparam int VT_W     = 36;   // tangential velocity, signed
    localparam int VTM_W    = 35;
    localparam int T2_W     = 72;   // |vt|^2
    localparam int NT_W     = 36;   // isqrt(|vt|^2)
    localparam int TN_NUM_W = VTM_W + FRAC_W;
    localparam int TN_W     = 18;   // normalised tangential magnitude

    localparam int SP_W     = GAIN_W + DIF_W;
    localparam int SV_W     = SP_W - FRAC_W;
    localparam int DP_W     = GAIN_W + VN_W;
    localparam int DV_W     = DP_W - FRAC_W;
    localparam int SM_W     = GAIN_W + ND_W;
    localparam int SMAG_W   = SM_W - FRAC_W;
    localparam int SPLIT_W  = 25;
    localparam int FL_W     = GAIN_W + SPLIT_W;
    localparam int FH_W     = GAIN_W + SMAG_W - SPLIT_W;
    localparam int FP_W     = GAIN_W + SMAG_W;
    localparam int FA_W     = FP_W - FRAC_W;
    localparam int FWL_W    = HALF_W + TN_W;
    localparam int FWH_W    = FA_W - HALF_W + TN_W;
    localparam int FWP_W    = FA_W + TN_W;
    localparam int FW_W     = FWP_W - FRAC_W;
    localparam int FM_W     = 61;
    localparam int SUM_W    = 64;

    localparam logic [T2_W-1:0] UNIT_SQ     = T2_W'(64'h1_0000_0000);
    localparam logic [FW_W-1:0] FRICT_CLAMP = FW_W'(64'h1000_0000_0000_0000);

    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_SPRING   = 2'd0;
    localparam logic [1:0] REG_DAMPING  = 2'd1;
    localparam logic [1:0] REG_FRICTION = 2'd2;

    typedef struct packed {
        logic [SQ_W-1:0]                pmag;
        logic                           pn;
        logic [SQ_W-1:0]                d2;
        logic [NLANE-1:0][DIF_W-1:0]    d;
        logic [NLANE-1:0][DIF_W-1:0]    v;
    } rt_side_t;

    typedef struct packed {
        logic                           pn;
        logic                           pmag_nz;
        logic                           dz;
        logic [ND_W-1:0]                nd;
        logic [NLANE-1:0][DIF_W-1:0]    d;
        logic [NLANE-1:0][DIF_W-1:0]    v;
    } vn_side_t;

    typedef struct packed {
        logic                           big;
        logic                           pn;
        logic                           damp_en;
        logic [ND_W-1:0]                nd;
        logic [NLANE-1:0][DIF_W-1:0]    d;
        logic [NLANE-1:0][VT_W-1:0]     vt;
        logic [NLANE-1:0][VN_W-1:0]     vnmag;
    } nt_side_t;

    typedef struct packed {
        logic                           damp;
        logic [NLANE-1:0]               dneg;
        logic [NLANE-1:0]               vneg;
        logic [NLANE-1:0]               tneg;
    } sgn_t;

endpackage

// File: design/pcf_div.sv
// Pipelined restoring divider, three lanes over one shared divisor, one quotient bit a stage.
module pcf_div
    import pcf_pkg::*;
#(
    parameter int NW = NUM_W,
    parameter int DW = SQ_W,
    parameter int QW = VN_W,
    parameter int SW = 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] num [NLANE],
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [QW-1:0] quo [NLANE],
    output logic [SW-1:0] side_out
);

    localparam int CW = DW + QW;

    logic          valid_reg [QW+1];
    logic [NW-1:0] rem_reg   [QW+1][NLANE];
    logic [QW-1:0] q_reg     [QW+1][NLANE];
    logic [DW-1:0] den_reg   [QW+1];
    logic [SW-1:0] side_reg  [QW+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else if (en)
            valid_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < NLANE; l++)
            begin
                rem_reg[0][l] <= num[l];
                q_reg[0][l]   <= '0;
            end
            den_reg[0]  <= den;
            side_reg[0] <= side_in;
        end
    end

    for (genvar j = 0; j < QW; j++)
    begin : g_step
        localparam int B = QW - 1 - j;
        logic [CW-1:0] trial;
        logic [NW-1:0] rem_next [NLANE];
        logic [QW-1:0] q_next   [NLANE];

        assign trial = CW'(den_reg[j]) << B;

        always_comb
        begin
            for (int l = 0; l < NLANE; l++)
            begin
                if (CW'(rem_reg[j][l]) >= trial)
                begin
                    rem_next[l] = rem_reg[j][l] - NW'(trial);
                    q_next[l]   = q_reg[j][l] | (QW'(1) << B);
                end
                else
                begin
                    rem_next[l] = rem_reg[j][l];
                    q_next[l]   = q_reg[j][l];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[j+1] <= 1'b0;
            else if (en)
                valid_reg[j+1] <= valid_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int l = 0; l < NLANE; l++)
                begin
                    rem_reg[j+1][l] <= rem_next[l];
                    q_reg[j+1][l]   <= q_next[l];
                end
                den_reg[j+1]  <= den_reg[j];
                side_reg[j+1] <= side_reg[j];
            end
        end
    end

    assign out_valid = valid_reg[QW];
    assign quo       = q_reg[QW];
    assign side_out  = side_reg[QW];

endmodule

// File: design/pcf_isqrt.sv
// Pipelined integer square root (floor), one result bit a stage.
module pcf_isqrt
    import pcf_pkg::*;
#(
    parameter int XW = SQ_W,
    parameter int SW = 1
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [XW-1:0]         rad,
    input  logic [SW-1:0]         side_in,
    output logic                  out_valid,
    output logic [(XW+1)/2-1:0]   root,
    output logic [SW-1:0]         side_out
);

    localparam int RW = (XW + 1) / 2;
    localparam int TW = 2 * RW + 1;

    logic          valid_reg [RW+1];
    logic [XW-1:0] rem_reg   [RW+1];
    logic [RW-1:0] r_reg     [RW+1];
    logic [SW-1:0] side_reg  [RW+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else if (en)
            valid_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= rad;
            r_reg[0]    <= '0;
            side_reg[0] <= side_in;
        end
    end

    for (genvar j = 0; j < RW; j++)
    begin : g_step
        localparam int B = RW - 1 - j;
        logic [TW-1:0] trial;
        logic [XW-1:0] rem_next;
        logic [RW-1:0] r_next;

        // (r + 2^b)^2 - r^2
        assign trial = (TW'(r_reg[j]) << (B + 1)) + (TW'(1) << (2 * B));

        always_comb
        begin
            if (TW'(rem_reg[j]) >= trial)
            begin
                rem_next = rem_reg[j] - XW'(trial);
                r_next   = r_reg[j] | (RW'(1) << B);
            end
            else
            begin
                rem_next = rem_reg[j];
                r_next   = r_reg[j];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[j+1] <= 1'b0;
            else if (en)
                valid_reg[j+1] <= valid_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j+1]  <= rem_next;
                r_reg[j+1]    <= r_next;
                side_reg[j+1] <= side_reg[j];
            end
        end
    end

    assign out_valid = valid_reg[RW];
    assign root      = r_reg[RW];
    assign side_out  = side_reg[RW];

endmodule

// File: design/penalty_contact_force_top.sv
// Penalty contact force: spring, one-sided normal damper and friction, fully pipelined.
// Throughput: one word per cycle while the skid register is empty.
// The two square roots and the two dividers run one bit a stage.
// A stalled output parks one word in a skid register; the pipeline freezes while it is full.
// Reset (rst_n, asynchronous, active low) clears all valid bits and the gain registers.
// Gain registers are read live by the pipeline; write them only when it is empty.
module penalty_contact_force_top
    import pcf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // obj_pos_x/y/z, obj_vel_x/y/z, hit_pos_x/y/z, hit_vel_x/y/z, 32 bits each
    input  logic [12*IN_W-1:0]      s_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // force_x, force_y, force_z, 48 bits each
    output logic [NLANE*OUT_W-1:0]  m_tdata,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    function automatic logic [DIF_W-1:0] abs_dif(input logic [DIF_W-1:0] a);
        return a[DIF_W-1] ? (~a + 1'b1) : a;
    endfunction

    function automatic logic [VT_W-1:0] abs_vt(input logic [VT_W-1:0] a);
        return a[VT_W-1] ? (~a + 1'b1) : a;
    endfunction

    // ---------------- configuration ----------------
    logic [GAIN_W-1:0] spring_reg, damping_reg, friction_reg;
    logic [1:0]        cfg_idx;

    assign cfg_idx = paddr[3:2];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spring_reg   <= '0;
            damping_reg  <= '0;
            friction_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (cfg_idx)
                REG_SPRING:   spring_reg   <= pwdata;
                REG_DAMPING:  damping_reg  <= pwdata;
                REG_FRICTION: friction_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_SPRING:   prdata = spring_reg;
            REG_DAMPING:  prdata = damping_reg;
            REG_FRICTION: prdata = friction_reg;
            default:      prdata = '0;
        endcase
    end

    // ---------------- flow control ----------------
    logic en;
    logic skid_valid_reg, out_valid_reg;
    logic p_valid;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // ---------------- stage 1: offset and relative velocity ----------------
    logic             s1_valid_reg;
    logic [DIF_W-1:0] s1_d_reg [NLANE];
    logic [DIF_W-1:0] s1_v_reg [NLANE];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en)
            s1_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < NLANE; l++)
            begin
                s1_d_reg[l] <= {s_tdata[IN_W*l+IN_W-1], s_tdata[IN_W*l +: IN_W]}
                    - {s_tdata[IN_W*(6+l)+IN_W-1], s_tdata[IN_W*(6+l) +: IN_W]};
                s1_v_reg[l] <= {s_tdata[IN_W*(3+l)+IN_W-1], s_tdata[IN_W*(3+l) +: IN_W]}
                    - {s_tdata[IN_W*(9+l)+IN_W-1], s_tdata[IN_W*(9+l) +: IN_W]};
            end
        end
    end

    // ---------------- stage 2: component products ----------------
    logic             s2_valid_reg;
    logic [SQ_W-1:0]  s2_dd_reg [NLANE];
    logic [SQ_W-1:0]  s2_dv_reg [NLANE];
    logic [NLANE-1:0] s2_neg_reg;
    logic [DIF_W-1:0] s2_d_reg [NLANE];
    logic [DIF_W-1:0] s2_v_reg [NLANE];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < NLANE; l++)
            begin
                s2_dd_reg[l]  <= SQ_W'(abs_dif(s1_d_reg[l])) * SQ_W'(abs_dif(s1_d_reg[l]));
                s2_dv_reg[l]  <= SQ_W'(abs_dif(s1_d_reg[l])) * SQ_W'(abs_dif(s1_v_reg[l]));
                s2_neg_reg[l] <= s1_d_reg[l][DIF_W-1] ^ s1_v_reg[l][DIF_W-1];
                s2_d_reg[l]   <= s1_d_reg[l];
                s2_v_reg[l]   <= s1_v_reg[l];
            end
        end
    end

    // ---------------- stage 3: |d|^2 and signed halves of v.d ----------------
    logic             s3_valid_reg;
    logic [SQ_W-1:0]  s3_d2_reg, s3_ppos_reg, s3_pneg_reg;
    logic [DIF_W-1:0] s3_d_reg [NLANE];
    logic [DIF_W-1:0] s3_v_reg [NLANE];
    logic [SQ_W-1:0]  s3_ppos_next, s3_pneg_next;

    always_comb
    begin
        s3_ppos_next = '0;
        s3_pneg_next = '0;
        for (int l = 0; l < NLANE; l++)
        begin
            if (s2_neg_reg[l])
                s3_pneg_next = s3_pneg_next + s2_dv_reg[l];
            else
                s3_ppos_next = s3_ppos_next + s2_dv_reg[l];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (en)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_d2_reg   <= s2_dd_reg[0] + s2_dd_reg[1] + s2_dd_reg[2];
            s3_ppos_reg <= s3_ppos_next;
            s3_pneg_reg <= s3_pneg_next;
            s3_d_reg    <= s2_d_reg;
            s3_v_reg    <= s2_v_reg;
        end
    end

    // ---------------- stage 4: |v.d| and its sign ----------------
    logic             s4_valid_reg;
    logic             s4_pn_reg;
    logic [SQ_W-1:0]  s4_pmag_reg, s4_d2_reg;
    logic [DIF_W-1:0] s4_d_reg [NLANE];
    logic [DIF_W-1:0] s4_v_reg [NLANE];
    rt_side_t         rt_in, rt_out;
    logic             rt_valid;
    logic [ND_W-1:0]  nd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else if (en)
            s4_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_pn_reg   <= s3_ppos_reg < s3_pneg_reg;
            s4_pmag_reg <= (s3_ppos_reg < s3_pneg_reg) ? s3_pneg_reg - s3_ppos_reg
                                                       : s3_ppos_reg - s3_pneg_reg;
            s4_d2_reg   <= s3_d2_reg;
            s4_d_reg    <= s3_d_reg;
            s4_v_reg    <= s3_v_reg;
        end
    end

    always_comb
    begin
        rt_in.pmag = s4_pmag_reg;
        rt_in.pn   = s4_pn_reg;
        rt_in.d2   = s4_d2_reg;
        for (int l = 0; l < NLANE; l++)
        begin
            rt_in.d[l] = s4_d_reg[l];
            rt_in.v[l] = s4_v_reg[l];
        end
    end

    pcf_isqrt #(
        .XW (SQ_W),
        .SW ($bits(rt_side_t))
    ) u_root_d (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s4_valid_reg),
        .rad       (s4_d2_reg),
        .side_in   (rt_in),
        .out_valid (rt_valid),
        .root      (nd),
        .side_out  (rt_out)
    );

    // ---------------- stages 5-6: numerator |v.d| * |d_i| ----------------
    logic            s5_valid_reg, s6_valid_reg;
    logic [SQ_W-1:0] s5_pl_reg [NLANE];
    logic [SQ_W-1:0] s5_ph_reg [NLANE];
    logic [SQ_W-1:0] s5_d2_reg, s6_d2_reg;
    vn_side_t        s5_side_reg, s6_side_reg, vn_out;
    logic [NUM_W-1:0] s6_num_reg [NLANE];
    logic            vn_valid;
    logic [VN_W-1:0] vq [NLANE];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s5_valid_reg <= rt_valid;
            s6_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < NLANE; l++)
            begin
                s5_pl_reg[l] <= SQ_W'(rt_out.pmag[HALF_W-1:0]) * SQ_W'(abs_dif(rt_out.d[l]));
                s5_ph_reg[l] <= SQ_W'(rt_out.pmag[SQ_W-1:HALF_W]) * SQ_W'(abs_dif(rt_out.d[l]));
                s6_num_reg[l] <= (NUM_W'(s5_ph_reg[l]) << HALF_W) + NUM_W'(s5_pl_reg[l]);
            end
            s5_side_reg.pn      <= rt_out.pn;
            s5_side_reg.pmag_nz <= rt_out.pmag != '0;
            s5_side_reg.dz      <= rt_out.d2 == '0;
            s5_side_reg.nd      <= nd;
            s5_side_reg.d       <= rt_out.d;
            s5_side_reg.v       <= rt_out.v;
            s5_d2_reg           <= rt_out.d2;
            s6_d2_reg           <= s5_d2_reg;
            s6_side_reg         <= s5_side_reg;
        end
    end

    pcf_div #(
        .NW (NUM_W),
        .DW (SQ_W),
        .QW (VN_W),
        .SW ($bits(vn_side_t))
    ) u_div_vn (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s6_valid_reg),
        .num       (s6_num_reg),
        .den       (s6_d2_reg),
        .side_in   (s6_side_reg),
        .out_valid (vn_valid),
        .quo       (vq),
        .side_out  (vn_out)
    );

    // ---------------- stages 7-9: tangential velocity and |vt|^2 ----------------
    logic            s7_valid_reg, s8_valid_reg, s9_valid_reg;
    nt_side_t        s7_side_reg, s8_side_reg, s9_side_reg, nt_out;
    logic [T2_W-1:0] s8_sq_reg [NLANE];
    logic [T2_W-1:0] s9_t2_reg, t2_sum;
    logic            nt_valid;
    logic [NT_W-1:0] nt;

    assign t2_sum = s8_sq_reg[0] + s8_sq_reg[1] + s8_sq_reg[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s7_valid_reg <= 1'b0;
            s8_valid_reg <= 1'b0;
            s9_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s7_valid_reg <= vn_valid;
            s8_valid_reg <= s7_valid_reg;
            s9_valid_reg <= s8_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        logic [VN_W-1:0] vnm;
        logic [VT_W-1:0] vns;
        nt_side_t        s9_side;
        if (en)
        begin
            for (int l = 0; l < NLANE; l++)
            begin
                // zero offset leaves no normal component
                vnm = vn_out.dz ? '0 : vq[l];
                vns = (vn_out.d[l][DIF_W-1] ^ vn_out.pn) ? -VT_W'(vnm) : VT_W'(vnm);
                s7_side_reg.vnmag[l] <= vnm;
                s7_side_reg.vt[l]    <= {{(VT_W-DIF_W){vn_out.v[l][DIF_W-1]}}, vn_out.v[l]}
                                        - vns;
                s8_sq_reg[l] <= T2_W'(abs_vt(s7_side_reg.vt[l][VT_W-1:0])) *
                                T2_W'(abs_vt(s7_side_reg.vt[l][VT_W-1:0]));
            end
            s7_side_reg.big     <= 1'b0;
            s7_side_reg.pn      <= vn_out.pn;
            s7_side_reg.damp_en <= !vn_out.pn && vn_out.pmag_nz;
            s7_side_reg.nd      <= vn_out.nd;
            s7_side_reg.d       <= vn_out.d;
            s8_side_reg         <= s7_side_reg;
            s9_t2_reg           <= t2_sum;
            s9_side             = s8_side_reg;
            s9_side.big         = t2_sum > UNIT_SQ;
            s9_side_reg         <= s9_side;
        end
    end

    pcf_isqrt #(
        .XW (T2_W),
        .SW ($bits(nt_side_t))
    ) u_root_t (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s9_valid_reg),
        .rad       (s9_t2_reg),
        .side_in   (s9_side_reg),
        .out_valid (nt_valid),
        .root      (nt),
        .side_out  (nt_out)
    );

    // ---------------- tangential normalisation ----------------
    logic [TN_NUM_W-1:0] tn_num [NLANE];
    logic                tn_valid;
    logic [TN_W-1:0]     tq [NLANE];
    nt_side_t            tn_out;

    always_comb
    begin
        logic [VT_W-1:0] vta;
        for (int l = 0; l < NLANE; l++)
        begin
            vta       = abs_vt(nt_out.vt[l]);
            tn_num[l] = {vta[VTM_W-1:0], {FRAC_W{1'b0}}};
        end
    end

    pcf_div #(
        .NW (TN_NUM_W),
        .DW (NT_W),
        .QW (TN_W),
        .SW ($bits(nt_side_t))
    ) u_div_tn (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (nt_valid),
        .num       (tn_num),
        .den       (nt),
        .side_in   (nt_out),
        .out_valid (tn_valid),
        .quo       (tq),
        .side_out  (tn_out)
    );

    // ---------------- stages 11-16: gains, friction, sum ----------------
    logic              s11_valid_reg, s12_valid_reg, s13_valid_reg;
    logic              s14_valid_reg, s15_valid_reg, s16_valid_reg;
    sgn_t              s11_sgn_reg, s12_sgn_reg, s13_sgn_reg, s14_sgn_reg, s15_sgn_reg;
    logic [SP_W-1:0]   s11_sp_reg [NLANE];
    logic [DP_W-1:0]   s11_dp_reg [NLANE];
    logic [SM_W-1:0]   s11_sm_reg;
    logic [TN_W-1:0]   s11_tn_reg [NLANE];
    logic [TN_W-1:0]   s12_tn_reg [NLANE];
    logic [TN_W-1:0]   s13_tn_reg [NLANE];
    logic [SV_W-1:0]   s12_sv_reg [NLANE];
    logic [SV_W-1:0]   s13_sv_reg [NLANE];
    logic [SV_W-1:0]   s14_sv_reg [NLANE];
    logic [SV_W-1:0]   s15_sv_reg [NLANE];
    logic [DV_W-1:0]   s12_dv_reg [NLANE];
    logic [DV_W-1:0]   s13_dv_reg [NLANE];
    logic [DV_W-1:0]   s14_dv_reg [NLANE];
    logic [DV_W-1:0]   s15_dv_reg [NLANE];
    logic [FL_W-1:0]   s12_fl_reg;
    logic [FH_W-1:0]   s12_fh_reg;
    logic [FA_W-1:0]   s13_fa_reg;
    logic [FWL_W-1:0]  s14_fwl_reg [NLANE];
    logic [FWH_W-1:0]  s14_fwh_reg [NLANE];
    logic [FM_W-1:0]   s15_fm_reg [NLANE];
    logic [OUT_W-1:0]  s16_force_reg [NLANE];
    logic [SMAG_W-1:0] smag;
    logic [FP_W-1:0]   fa_prod;

    assign smag    = s11_sm_reg[SM_W-1:FRAC_W];
    assign fa_prod = (FP_W'(s12_fh_reg) << SPLIT_W) + FP_W'(s12_fl_reg);
    assign p_valid = s16_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s11_valid_reg <= 1'b0;
            s12_valid_reg <= 1'b0;
            s13_valid_reg <= 1'b0;
            s14_valid_reg <= 1'b0;
            s15_valid_reg <= 1'b0;
            s16_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s11_valid_reg <= tn_valid;
            s12_valid_reg <= s11_valid_reg;
            s13_valid_reg <= s12_valid_reg;
            s14_valid_reg <= s13_valid_reg;
            s15_valid_reg <= s14_valid_reg;
            s16_valid_reg <= s15_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        logic [VT_W-1:0]  vtm;
        logic [FWP_W-1:0] fwp;
        logic [FW_W-1:0]  fw;
        logic [SUM_W-1:0] sp_t, dm_t, fr_t, sum;
        if (en)
        begin
            s11_sm_reg       <= SM_W'(spring_reg) * SM_W'(tn_out.nd);
            s11_sgn_reg.damp <= tn_out.damp_en;
            for (int l = 0; l < NLANE; l++)
            begin
                vtm = abs_vt(tn_out.vt[l]);
                // at or below unit length the tangential velocity is used as it stands
                s11_tn_reg[l] <= tn_out.big ? tq[l] : vtm[TN_W-1:0];
                s11_sp_reg[l] <= SP_W'(spring_reg) * SP_W'(abs_dif(tn_out.d[l]));
                s11_dp_reg[l] <= DP_W'(damping_reg) * DP_W'(tn_out.vnmag[l]);
                s11_sgn_reg.dneg[l] <= tn_out.d[l][DIF_W-1];
                s11_sgn_reg.vneg[l] <= tn_out.d[l][DIF_W-1] ^ tn_out.pn;
                s11_sgn_reg.tneg[l] <= tn_out.vt[l][VT_W-1];

                s12_sv_reg[l] <= s11_sp_reg[l][SP_W-1:FRAC_W];
                s12_dv_reg[l] <= s11_dp_reg[l][DP_W-1:FRAC_W];
                s12_tn_reg[l] <= s11_tn_reg[l];

                s13_sv_reg[l] <= s12_sv_reg[l];
                s13_dv_reg[l] <= s12_dv_reg[l];
                s13_tn_reg[l] <= s12_tn_reg[l];

                s14_fwl_reg[l] <= FWL_W'(s13_fa_reg[HALF_W-1:0]) * FWL_W'(s13_tn_reg[l]);
                s14_fwh_reg[l] <= FWH_W'(s13_fa_reg[FA_W-1:HALF_W]) * FWH_W'(s13_tn_reg[l]);
                s14_sv_reg[l]  <= s13_sv_reg[l];
                s14_dv_reg[l]  <= s13_dv_reg[l];

                fwp = (FWP_W'(s14_fwh_reg[l]) << HALF_W) + FWP_W'(s14_fwl_reg[l]);
                fw  = fwp[FWP_W-1:FRAC_W];
                s15_fm_reg[l] <= (fw > FRICT_CLAMP) ? FRICT_CLAMP[FM_W-1:0] : fw[FM_W-1:0];
                s15_sv_reg[l] <= s14_sv_reg[l];
                s15_dv_reg[l] <= s14_dv_reg[l];

                // every term opposes its own displacement or motion
                sp_t = s15_sgn_reg.dneg[l] ? SUM_W'(s15_sv_reg[l]) : -SUM_W'(s15_sv_reg[l]);
                if (s15_sgn_reg.damp)
                    dm_t = s15_sgn_reg.vneg[l] ? SUM_W'(s15_dv_reg[l]) : -SUM_W'(s15_dv_reg[l]);
                else
                    dm_t = '0;
                fr_t = s15_sgn_reg.tneg[l] ? SUM_W'(s15_fm_reg[l]) : -SUM_W'(s15_fm_reg[l]);
                sum  = sp_t + dm_t + fr_t;
                if (sum[SUM_W-1:OUT_W-1] == '0 || sum[SUM_W-1:OUT_W-1] == '1)
                    s16_force_reg[l] <= sum[OUT_W-1:0];
                else
                    s16_force_reg[l] <= {sum[SUM_W-1], {(OUT_W-1){!sum[SUM_W-1]}}};
            end
            s12_fl_reg  <= FL_W'(friction_reg) * FL_W'(smag[SPLIT_W-1:0]);
            s12_fh_reg  <= FH_W'(friction_reg) * FH_W'(smag[SMAG_W-1:SPLIT_W]);
            s12_sgn_reg <= s11_sgn_reg;
            s13_fa_reg  <= fa_prod[FP_W-1:FRAC_W];
            s13_sgn_reg <= s12_sgn_reg;
            s14_sgn_reg <= s13_sgn_reg;
            s15_sgn_reg <= s14_sgn_reg;
        end
    end

    // ---------------- output register and skid ----------------
    logic [OUT_W-1:0] out_force_reg  [NLANE];
    logic [OUT_W-1:0] skid_force_reg [NLANE];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (m_tready)
                skid_valid_reg <= 1'b0;
        end
        else if (p_valid)
        begin
            if (out_valid_reg && !m_tready)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (m_tready)
                out_force_reg <= skid_force_reg;
        end
        else if (p_valid)
        begin
            if (out_valid_reg && !m_tready)
                skid_force_reg <= s16_force_reg;
            else
                out_force_reg <= s16_force_reg;
        end
    end

    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        for (int l = 0; l < NLANE; l++)
            m_tdata[OUT_W*l +: OUT_W] = out_force_reg[l];
    end

    // ---------------- checks ----------------
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held with empty output register");

    a_skid_held: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !m_tready) |=> (skid_valid_reg && $stable(skid_force_reg[0])))
        else $error("skid word lost under stall");

    a_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        (p_valid && !en) |=> (p_valid && $stable(s16_force_reg[0])))
        else $error("pipeline moved while frozen");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !skid_valid_reg && !p_valid) |=> !m_tvalid)
        else $error("output word repeated");

endmodule
